@@ rtl/ptpc_pkg.sv @@
`default_nettype none
package ptpc_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_DISTANCE_SCALE     = 8'd0;
    localparam logic [7:0] REG_INTEGER_MATCH_MODE = 8'd1;

    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam int          FRAC_W      = 20;
    localparam int          NUM_CELLS   = 20;
    localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
    localparam logic [39:0] MODEL_MAX   = 40'hFF_FFFF_FFFF;

    // Per-item fields that travel down the whole chain
    typedef struct packed {
        logic [15:0]        pixel;
        logic               kind;
        logic signed [15:0] slope;
        logic signed [23:0] amp;
        logic               imode;
    } ctx_t;

    // Side data carried through the log2 cells
    typedef struct packed {
        logic [4:0]         n;
        logic               zero;
        logic signed [27:0] tc;
    } aux_t;

    // Rounded integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt_round(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bitv;
        logic [63:0] rem;
        r    = '0;
        bitv = 64'd1 << 62;
        rem  = n;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (rem >= r + bitv) begin
                    rem = rem - (r + bitv);
                    r   = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        if (n - r * r > r) r = r + 64'd1;
        return r;
    endfunction

    // 2^(2^-k) in Q.30, for k from 1 to NUM_CELLS
    function automatic logic [30:0] pow_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 1; j <= NUM_CELLS; j++) begin
            if (j <= k) c = isqrt_round(c << 30);
        end
        return c[30:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/ptpc_log_cell.sv @@
`default_nettype none
module ptpc_log_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  ptpc_pkg::ctx_t  ctx_in,
    input  ptpc_pkg::aux_t  aux_in,
    input  logic [30:0]     m_in,
    input  logic [19:0]     frac_in,
    output logic            vout,
    output ptpc_pkg::ctx_t  ctx_out,
    output ptpc_pkg::aux_t  aux_out,
    output logic [30:0]     m_out,
    output logic [19:0]     frac_out
);
    import ptpc_pkg::*;

    logic [61:0] sq;
    logic [31:0] msh;
    logic [30:0] m_next;
    logic [19:0] frac_next;
    logic        v_reg;
    ctx_t        ctx_reg;
    aux_t        aux_reg;
    logic [30:0] m_reg;
    logic [19:0] frac_reg;

    // Square the mantissa and pull out one fraction bit
    always_comb
    begin
        sq  = m_in * m_in;
        msh = sq[61:30];
        if (msh[31])
        begin
            m_next    = msh[31:1];
            frac_next = {frac_in[18:0], 1'b1};
        end
        else
        begin
            m_next    = msh[30:0];
            frac_next = {frac_in[18:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg  <= ctx_in;
            aux_reg  <= aux_in;
            m_reg    <= m_next;
            frac_reg <= frac_next;
        end
    end

    assign vout     = v_reg;
    assign ctx_out  = ctx_reg;
    assign aux_out  = aux_reg;
    assign m_out    = m_reg;
    assign frac_out = frac_reg;

endmodule
`default_nettype wire

@@ rtl/ptpc_pow_cell.sv @@
`default_nettype none
module ptpc_pow_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  ptpc_pkg::ctx_t     ctx_in,
    input  logic signed [5:0]  ip_in,
    input  logic [30:0]        p_in,
    input  logic [19:0]        frac_in,
    input  logic [30:0]        coef,
    output logic               vout,
    output ptpc_pkg::ctx_t     ctx_out,
    output logic signed [5:0]  ip_out,
    output logic [30:0]        p_out,
    output logic [19:0]        frac_out
);
    import ptpc_pkg::*;

    localparam logic [61:0] HALF = 62'd1 << 29;

    logic [61:0]        prod;
    logic [30:0]        p_next;
    logic               v_reg;
    ctx_t               ctx_reg;
    logic signed [5:0]  ip_reg;
    logic [30:0]        p_reg;
    logic [19:0]        frac_reg;

    // Multiply in this cell's constant when the leading fraction bit is set
    always_comb
    begin
        prod = p_in * coef + HALF;
        if (frac_in[19])
            p_next = prod[60:30];
        else
            p_next = p_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg  <= ctx_in;
            ip_reg   <= ip_in;
            p_reg    <= p_next;
            frac_reg <= {frac_in[18:0], 1'b0};
        end
    end

    assign vout     = v_reg;
    assign ctx_out  = ctx_reg;
    assign ip_out   = ip_reg;
    assign p_out    = p_reg;
    assign frac_out = frac_reg;

endmodule
`default_nettype wire

@@ rtl/ptpc_out_buf.sv @@
`default_nettype none
module ptpc_out_buf (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tail_valid,
    input  logic [31:0] tail_data,
    input  logic        stall,
    output logic        en,
    output logic        out_valid,
    output logic [31:0] out_data
);
    logic        out_v_reg;
    logic [31:0] out_d_reg;
    logic        skid_v_reg;
    logic [31:0] skid_d_reg;

    // Advance the chain whenever the skid slot is free
    assign en = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!skid_v_reg)
        begin
            if (!out_v_reg || !stall)
                out_v_reg <= tail_valid;
            else if (tail_valid)
                skid_v_reg <= 1'b1;
        end
        else if (!stall)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            if (!out_v_reg || !stall)
                out_d_reg <= tail_data;
            else if (tail_valid)
                skid_d_reg <= tail_data;
        end
        else if (!stall)
        begin
            out_d_reg <= skid_d_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_d_reg;

endmodule
`default_nettype wire

@@ rtl/persistence_trail_pixel_correction.sv @@
// Throughput: one transaction per cycle while in_stall is low; the log2 and 2^x chains each have 20 cells,
// one multiplier per cell, and every stage advances together.
// A two-entry output buffer keeps input open while its skid entry is empty; that entry fills when the output stalls.
// Reset clears all valid bits and loads distance_scale 256, integer_match_mode 0.
`default_nettype none
module persistence_trail_pixel_correction (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        pixel_value,
    input  logic signed [12:0] row_distance,
    input  logic               curve_kind,
    input  logic signed [15:0] slope,
    input  logic signed [23:0] amplitude,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] corrected_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ptpc_pkg::*;

    localparam logic signed [45:0] EXP_LIM  = 46'sd67108864;
    localparam logic signed [64:0] RND_INT  = 65'sd134217728;
    localparam logic signed [64:0] RND_NORM = 65'sd524288;
    localparam logic signed [46:0] I32_MAX  = 47'sd2147483647;
    localparam logic signed [46:0] I32_MIN  = -47'sd2147483648;

    logic        en;
    logic [15:0] scale_reg;
    logic        imode_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            imode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISTANCE_SCALE:     scale_reg <= cfg_data;
                REG_INTEGER_MATCH_MODE: imode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_stall = !en;

    // Stage 0: scale the row distance (forced to 1 for curve_kind 0 when not positive)
    logic signed [12:0] dd;
    logic signed [29:0] prod_next;
    logic               s0_v_reg;
    ctx_t               s0_ctx_reg;
    logic signed [29:0] s0_prod_reg;

    always_comb
    begin
        if (!curve_kind && (row_distance <= 13'sd0))
            dd = 13'sd1;
        else
            dd = row_distance;
        prod_next = $signed({1'b0, scale_reg}) * dd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (en)
            s0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctx_reg  <= '{pixel: pixel_value, kind: curve_kind, slope: slope,
                             amp: amplitude, imode: imode_reg};
            s0_prod_reg <= prod_next;
        end
    end

    // Stage 1: normalize for log2, or form and clamp the exponent argument
    logic [28:0]        x1;
    logic [4:0]         n_c;
    logic [30:0]        m_c;
    logic signed [45:0] t_c;
    logic signed [27:0] tc_c;
    logic               s1_v_reg;
    ctx_t               s1_ctx_reg;
    aux_t               s1_aux_reg;
    logic [30:0]        s1_m_reg;

    always_comb
    begin
        x1  = s0_prod_reg[28:0];
        n_c = 5'd0;
        for (int i = 0; i < 29; i++)
        begin
            if (x1[i]) n_c = 5'(i);
        end
        m_c = {2'b00, x1} << (5'd30 - n_c);
        t_c = $signed(s0_ctx_reg.slope) * s0_prod_reg;
        if (t_c > EXP_LIM)
            tc_c = 28'(EXP_LIM);
        else if (t_c < -EXP_LIM)
            tc_c = 28'(-EXP_LIM);
        else
            tc_c = 28'(t_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg <= s0_ctx_reg;
            s1_aux_reg <= '{n: n_c, zero: (x1 == 29'd0), tc: tc_c};
            s1_m_reg   <= m_c;
        end
    end

    // log2 chain: one squaring cell per fraction bit
    logic        lv    [0:NUM_CELLS];
    ctx_t        lctx  [0:NUM_CELLS];
    aux_t        laux  [0:NUM_CELLS];
    logic [30:0] lm    [0:NUM_CELLS];
    logic [19:0] lfrac [0:NUM_CELLS];

    assign lv[0]    = s1_v_reg;
    assign lctx[0]  = s1_ctx_reg;
    assign laux[0]  = s1_aux_reg;
    assign lm[0]    = s1_m_reg;
    assign lfrac[0] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_log
        ptpc_log_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vin      (lv[g]),
            .ctx_in   (lctx[g]),
            .aux_in   (laux[g]),
            .m_in     (lm[g]),
            .frac_in  (lfrac[g]),
            .vout     (lv[g+1]),
            .ctx_out  (lctx[g+1]),
            .aux_out  (laux[g+1]),
            .m_out    (lm[g+1]),
            .frac_out (lfrac[g+1])
        );
    end

    // Stage E: exponent product
    logic [5:0]         lhi;
    logic signed [25:0] log_c;
    logic signed [58:0] pe_c;
    logic signed [58:0] xe_c;
    logic               se_v_reg;
    ctx_t               se_ctx_reg;
    logic               se_zero_reg;
    logic signed [58:0] se_prod_reg;

    always_comb
    begin
        lhi   = 6'({1'b0, laux[NUM_CELLS].n} - 6'd8);
        log_c = $signed({lhi, lfrac[NUM_CELLS]});
        pe_c  = $signed(lctx[NUM_CELLS].slope) * log_c;
        xe_c  = laux[NUM_CELLS].tc * $signed({1'b0, LOG2E_Q30});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            se_v_reg <= 1'b0;
        else if (en)
            se_v_reg <= lv[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_ctx_reg  <= lctx[NUM_CELLS];
            se_zero_reg <= laux[NUM_CELLS].zero;
            se_prod_reg <= lctx[NUM_CELLS].kind ? xe_c : pe_c;
        end
    end

    // Stage F: split exponent into integer and fraction, clamp the integer part, handle zero distance
    logic signed [58:0] sh_c;
    logic signed [9:0]  ipf_c;
    logic signed [5:0]  ip_c;
    logic [19:0]        fr_c;
    logic               sf_v_reg;
    ctx_t               sf_ctx_reg;
    logic signed [5:0]  sf_ip_reg;
    logic [19:0]        sf_frac_reg;

    always_comb
    begin
        if (se_ctx_reg.kind)
            sh_c = se_prod_reg >>> 30;
        else
            sh_c = se_prod_reg >>> 12;
        ipf_c = $signed(sh_c[29:20]);
        fr_c  = sh_c[19:0];
        if (!se_ctx_reg.kind && se_zero_reg)
        begin
            fr_c = '0;
            if (se_ctx_reg.slope > 16'sd0)
                ip_c = -6'sd22;
            else if (se_ctx_reg.slope == 16'sd0)
                ip_c = 6'sd0;
            else
                ip_c = 6'sd20;
        end
        else if (ipf_c >= 10'sd20)
            ip_c = 6'sd20;
        else if (ipf_c < -10'sd21)
            ip_c = -6'sd22;
        else
            ip_c = ipf_c[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sf_v_reg <= 1'b0;
        else if (en)
            sf_v_reg <= se_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_ctx_reg  <= se_ctx_reg;
            sf_ip_reg   <= ip_c;
            sf_frac_reg <= fr_c;
        end
    end

    // 2^x chain: one constant multiply cell per fraction bit
    logic              pv    [0:NUM_CELLS];
    ctx_t              pctx  [0:NUM_CELLS];
    logic signed [5:0] pip   [0:NUM_CELLS];
    logic [30:0]       pp    [0:NUM_CELLS];
    logic [19:0]       pfrac [0:NUM_CELLS];

    assign pv[0]    = sf_v_reg;
    assign pctx[0]  = sf_ctx_reg;
    assign pip[0]   = sf_ip_reg;
    assign pp[0]    = 31'd1 << 30;
    assign pfrac[0] = sf_frac_reg;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_pow
        ptpc_pow_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vin      (pv[g]),
            .ctx_in   (pctx[g]),
            .ip_in    (pip[g]),
            .p_in     (pp[g]),
            .frac_in  (pfrac[g]),
            .coef     (pow_coef(g + 1)),
            .vout     (pv[g+1]),
            .ctx_out  (pctx[g+1]),
            .ip_out   (pip[g+1]),
            .p_out    (pp[g+1]),
            .frac_out (pfrac[g+1])
        );
    end

    // Stage G: place the mantissa into Q.20 and saturate
    logic [5:0]  shamt;
    logic [39:0] model_c;
    logic        sg_v_reg;
    ctx_t        sg_ctx_reg;
    logic [39:0] sg_model_reg;

    always_comb
    begin
        shamt = 6'(6'sd19 - pip[NUM_CELLS]);
        if (pip[NUM_CELLS] >= 6'sd20)
            model_c = MODEL_MAX;
        else if (pip[NUM_CELLS] < -6'sd21)
            model_c = '0;
        else
            model_c = {pp[NUM_CELLS], 9'b0} >> shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sg_v_reg <= 1'b0;
        else if (en)
            sg_v_reg <= pv[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg_ctx_reg   <= pctx[NUM_CELLS];
            sg_model_reg <= model_c;
        end
    end

    // Stage H: amplitude times model as two partial products
    logic signed [44:0] hi_c;
    logic signed [44:0] lo_c;
    logic               sh_v_reg;
    ctx_t               sh_ctx_reg;
    logic signed [44:0] sh_hi_reg;
    logic signed [44:0] sh_lo_reg;

    always_comb
    begin
        hi_c = $signed(sg_ctx_reg.amp) * $signed({1'b0, sg_model_reg[39:20]});
        lo_c = $signed(sg_ctx_reg.amp) * $signed({1'b0, sg_model_reg[19:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_v_reg <= 1'b0;
        else if (en)
            sh_v_reg <= sg_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_ctx_reg <= sg_ctx_reg;
            sh_hi_reg  <= hi_c;
            sh_lo_reg  <= lo_c;
        end
    end

    // Stage I: combine partial products
    logic signed [64:0] hi_ext;
    logic signed [64:0] lo_ext;
    logic               si_v_reg;
    ctx_t               si_ctx_reg;
    logic signed [64:0] si_p_reg;

    assign hi_ext = sh_hi_reg;
    assign lo_ext = sh_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            si_v_reg <= 1'b0;
        else if (en)
            si_v_reg <= sh_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            si_ctx_reg <= sh_ctx_reg;
            si_p_reg   <= (hi_ext <<< 20) + lo_ext;
        end
    end

    // Stage J: round the delta for both modes
    logic signed [64:0] q_c;
    logic signed [64:0] qf_c;
    logic signed [64:0] qn_c;
    logic               adj_c;
    logic               sj_v_reg;
    ctx_t               sj_ctx_reg;
    logic [15:0]        sj_d16_reg;
    logic signed [44:0] sj_dn_reg;

    always_comb
    begin
        q_c   = si_p_reg + RND_INT;
        qf_c  = q_c >>> 28;
        adj_c = q_c[64] && (q_c[27:0] != 28'd0);
        qn_c  = (si_p_reg + RND_NORM) >>> 20;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sj_v_reg <= 1'b0;
        else if (en)
            sj_v_reg <= si_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sj_ctx_reg <= si_ctx_reg;
            sj_d16_reg <= qf_c[15:0] + {15'b0, adj_c};
            sj_dn_reg  <= qn_c[44:0];
        end
    end

    // Final subtract: wrap in integer mode, saturate otherwise
    logic [15:0]        v16;
    logic signed [46:0] diff;
    logic [31:0]        tail_data;

    always_comb
    begin
        v16  = sj_ctx_reg.pixel - sj_d16_reg;
        diff = $signed({23'b0, sj_ctx_reg.pixel, 8'b0}) - sj_dn_reg;
        if (sj_ctx_reg.imode)
            tail_data = {8'b0, v16, 8'b0};
        else if (diff > I32_MAX)
            tail_data = 32'h7FFF_FFFF;
        else if (diff < I32_MIN)
            tail_data = 32'h8000_0000;
        else
            tail_data = diff[31:0];
    end

    logic [31:0] out_data;

    ptpc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (sj_v_reg),
        .tail_data  (tail_data),
        .stall      (out_stall),
        .en         (en),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    assign corrected_value = $signed(out_data);

endmodule
`default_nettype wire
